FILE: hdl/hkrd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hkrd_pkg
// shared constants, command word and modifier order for the report differ
// ----------------------------------------------------------------------------
package hkrd_pkg;

  localparam int KEY_SLOTS_DEF = 6;
  localparam int REPORT_KEYS   = 6;
  localparam int KEY_IDX_W     = 3;
  localparam int MOD_BITS      = 8;
  localparam int STEP_W        = 4;

  localparam logic [4:0] MOD_CODE_BASE = 5'b11100;

  typedef struct packed {
    logic              load;
    logic              clear;
    logic              do_mod;
    logic              do_key;
    logic              do_rel;
    logic              flush;
    logic [STEP_W-1:0] step;
  } cmd_t;

  // report order of modifier bits: lshift, rshift, lalt, ralt, lctrl, rctrl, lgui, rgui
  function automatic logic [2:0] mod_bit(input logic [2:0] idx);
    logic [2:0] b;
    unique case (idx)
      3'd0:    b = 3'd1;
      3'd1:    b = 3'd5;
      3'd2:    b = 3'd2;
      3'd3:    b = 3'd6;
      3'd4:    b = 3'd0;
      3'd5:    b = 3'd4;
      3'd6:    b = 3'd3;
      default: b = 3'd7;
    endcase
    return b;
  endfunction

endpackage
`default_nettype wire

FILE: hdl/hkrd_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hkrd_ctrl
// phase sequencer: modifiers, report keys, tracked slots, final flush
// ----------------------------------------------------------------------------
module hkrd_ctrl
  import hkrd_pkg::*;
#(
  parameter int KEY_SLOTS = KEY_SLOTS_DEF
) (
  input  wire  clk_i,
  input  wire  rst_ni,
  input  wire  start_i,
  input  wire  keyboard_present_i,
  output logic busy_o,
  output cmd_t cmd_o
);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_MODS  = 5'b00010,
    ST_KEYS  = 5'b00100,
    ST_RELS  = 5'b01000,
    ST_FLUSH = 5'b10000
  } state_e;

  state_e            state_q, state_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic              accept;

  assign accept = start_i && (state_q == ST_IDLE);

  always_comb begin
    state_d = state_q;
    step_d  = step_q + STEP_W'(1);
    unique case (state_q)
      ST_IDLE: begin
        step_d = '0;
        if (accept && keyboard_present_i) state_d = ST_MODS;
      end
      ST_MODS: begin
        if (step_q == STEP_W'(MOD_BITS - 1)) begin
          state_d = ST_KEYS;
          step_d  = '0;
        end
      end
      ST_KEYS: begin
        if (step_q == STEP_W'(REPORT_KEYS - 1)) begin
          state_d = ST_RELS;
          step_d  = '0;
        end
      end
      ST_RELS: begin
        if (step_q == STEP_W'(KEY_SLOTS - 1)) begin
          state_d = ST_FLUSH;
          step_d  = '0;
        end
      end
      ST_FLUSH: begin
        state_d = ST_IDLE;
        step_d  = '0;
      end
      default: begin
        state_d = ST_IDLE;
        step_d  = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  assign busy_o        = (state_q != ST_IDLE);
  assign cmd_o.load    = accept && keyboard_present_i;
  assign cmd_o.clear   = accept && !keyboard_present_i;
  assign cmd_o.do_mod  = (state_q == ST_MODS);
  assign cmd_o.do_key  = (state_q == ST_KEYS);
  assign cmd_o.do_rel  = (state_q == ST_RELS);
  assign cmd_o.flush   = (state_q == ST_FLUSH);
  assign cmd_o.step    = step_q;

`ifndef NO_ASSERTIONS
  a_load_starts_mods: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> (state_q == ST_MODS) && (step_q == '0))
    else $error("load did not enter modifier phase at step zero");
  a_clear_stays_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.clear |=> !busy_o)
    else $error("absent keyboard report made the block busy");
  a_flush_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FLUSH) |=> !busy_o)
    else $error("flush not followed by idle");
`endif

endmodule
`default_nettype wire

FILE: hdl/hkrd_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hkrd_datapath
// report registers, key slot table, event candidate logic and output stage
// ----------------------------------------------------------------------------
module hkrd_datapath
  import hkrd_pkg::*;
#(
  parameter int KEY_SLOTS = KEY_SLOTS_DEF
) (
  input  wire        clk_i,
  input  wire        rst_ni,
  input  cmd_t       cmd_i,
  input  wire  [7:0] modifier_bits_i,
  input  wire  [2:0] key_count_i,
  input  wire  [7:0] key_a_i,
  input  wire  [7:0] key_b_i,
  input  wire  [7:0] key_c_i,
  input  wire  [7:0] key_d_i,
  input  wire  [7:0] key_e_i,
  input  wire  [7:0] key_f_i,
  output logic       result_valid_o,
  output logic       pressed_o,
  output logic [7:0] code_o,
  output logic       last_o
);

  localparam int SLOT_W = (KEY_SLOTS > 1) ? $clog2(KEY_SLOTS) : 1;

  logic [7:0] mods_q, changed_q, prev_q;
  logic [2:0] cnt_q;
  logic [7:0] keys_q  [REPORT_KEYS];
  logic [7:0] slots_q [KEY_SLOTS];

  logic       pend_v_q, pend_p_q;
  logic [7:0] pend_c_q;
  logic       strobe_q, pressed_q, last_q;
  logic [7:0] code_q;

  logic [2:0]        mb;
  logic [7:0]        key_k, slot_k;
  logic              key_in_cnt, known, free_found, held;
  logic [SLOT_W-1:0] free_idx, rel_idx;
  logic              cand_v, cand_p;
  logic [7:0]        cand_c;
  logic              ins_en, rel_en;

  assign mb      = mod_bit(cmd_i.step[2:0]);
  assign key_k   = keys_q[cmd_i.step[KEY_IDX_W-1:0]];
  assign rel_idx = cmd_i.step[SLOT_W-1:0];
  assign slot_k  = slots_q[rel_idx];
  assign key_in_cnt = (cmd_i.step < {1'b0, cnt_q});

  // parallel compares against the whole slot table, first free slot wins
  always_comb begin
    known      = 1'b0;
    free_found = 1'b0;
    free_idx   = '0;
    for (int j = KEY_SLOTS - 1; j >= 0; j--) begin
      if (slots_q[j] == key_k) known = 1'b1;
      if (slots_q[j] == 8'd0) begin
        free_found = 1'b1;
        free_idx   = SLOT_W'(j);
      end
    end
  end

  always_comb begin
    held = 1'b0;
    for (int i = 0; i < REPORT_KEYS; i++) begin
      if ((KEY_IDX_W'(i) < cnt_q) && (keys_q[i] == slot_k)) held = 1'b1;
    end
  end

  assign ins_en = cmd_i.do_key && key_in_cnt && (key_k != 8'd0) && !known && free_found;
  assign rel_en = cmd_i.do_rel && (slot_k != 8'd0) && !held;

  always_comb begin
    cand_v = 1'b0;
    cand_p = 1'b0;
    cand_c = 8'd0;
    priority if (cmd_i.do_mod) begin
      cand_v = changed_q[mb];
      cand_p = mods_q[mb];
      cand_c = {MOD_CODE_BASE, mb};
    end else if (ins_en) begin
      cand_v = 1'b1;
      cand_p = 1'b1;
      cand_c = key_k;
    end else if (rel_en) begin
      cand_v = 1'b1;
      cand_p = 1'b0;
      cand_c = slot_k;
    end
  end

  // report capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mods_q    <= modifier_bits_i;
      changed_q <= modifier_bits_i ^ prev_q;
      cnt_q     <= (key_count_i == 3'd7) ? 3'(REPORT_KEYS) : key_count_i;
      keys_q[0] <= key_a_i;
      keys_q[1] <= key_b_i;
      keys_q[2] <= key_c_i;
      keys_q[3] <= key_d_i;
      keys_q[4] <= key_e_i;
      keys_q[5] <= key_f_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q <= 8'd0;
    end else if (cmd_i.load) begin
      prev_q <= modifier_bits_i;
    end
  end

  // slot table
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int j = 0; j < KEY_SLOTS; j++) slots_q[j] <= 8'd0;
    end else if (cmd_i.clear) begin
      for (int j = 0; j < KEY_SLOTS; j++) slots_q[j] <= 8'd0;
    end else if (ins_en) begin
      slots_q[free_idx] <= key_k;
    end else if (rel_en) begin
      slots_q[rel_idx] <= 8'd0;
    end
  end

  // one event held back so the final one can be flagged
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_v_q <= 1'b0;
      strobe_q <= 1'b0;
    end else begin
      strobe_q <= 1'b0;
      if (cand_v) begin
        if (pend_v_q) strobe_q <= 1'b1;
        pend_v_q <= 1'b1;
      end else if (cmd_i.flush && pend_v_q) begin
        strobe_q <= 1'b1;
        pend_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cand_v) begin
      pend_p_q  <= cand_p;
      pend_c_q  <= cand_c;
      pressed_q <= pend_p_q;
      code_q    <= pend_c_q;
      last_q    <= 1'b0;
    end else if (cmd_i.flush) begin
      pressed_q <= pend_p_q;
      code_q    <= pend_c_q;
      last_q    <= 1'b1;
    end
  end

  assign result_valid_o = strobe_q;
  assign pressed_o      = pressed_q;
  assign code_o         = code_q;
  assign last_o         = last_q;

`ifndef NO_ASSERTIONS
  a_last_from_flush: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (strobe_q && last_q) |-> $past(cmd_i.flush))
    else $error("final word not produced by flush");
  a_flush_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.flush |=> !pend_v_q)
    else $error("pending word survived flush");
  a_clear_frees: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.clear |=> (slots_q[0] == 8'd0))
    else $error("slot table not cleared");
  a_one_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ins_en && rel_en))
    else $error("insert and release in one step");
`endif

endmodule
`default_nettype wire

FILE: hdl/hid_keyboard_report_differ.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hid_keyboard_report_differ
// turns boot keyboard reports into key press and release words
// ----------------------------------------------------------------------------
//
// channel | direction | handshake                     | payload
// --------+-----------+-------------------------------+----------------------------------
// report  | in        | start_i, busy_o               | keyboard_present_i, modifier_bits_i,
//         |           |                               | key_count_i, key_a_i .. key_f_i
// event   | out       | result_valid_o (one cycle)    | pressed_o, code_o, last_o
//
// a present report keeps busy_o high through the step sequence:
//   8 modifier steps, 6 report key steps, KEY_SLOTS slot steps, one flush step;
//   a new report is taken only once busy_o is low again; the step sequencer sets this
// a report with no keyboard clears the slot table in its accept cycle, busy_o stays low
// a word found by a step is held until the next word is found, then leaves in the cycle after;
//   the final word comes out in the cycle after the flush step
// reset clears the slot table, the stored modifiers and the sequencer
// the receiver cannot stall: every word is on the ports for exactly one cycle
//
module hid_keyboard_report_differ
  import hkrd_pkg::*;
#(
  parameter int KEY_SLOTS = KEY_SLOTS_DEF
) (
  input  wire        clk_i,
  input  wire        rst_ni,
  input  wire        start_i,
  output logic       busy_o,
  input  wire        keyboard_present_i,
  input  wire  [7:0] modifier_bits_i,
  input  wire  [2:0] key_count_i,
  input  wire  [7:0] key_a_i,
  input  wire  [7:0] key_b_i,
  input  wire  [7:0] key_c_i,
  input  wire  [7:0] key_d_i,
  input  wire  [7:0] key_e_i,
  input  wire  [7:0] key_f_i,
  output logic       result_valid_o,
  output logic       pressed_o,
  output logic [7:0] code_o,
  output logic       last_o
);

  // command word from sequencer to datapath
  cmd_t cmd;

  hkrd_ctrl #(
    .KEY_SLOTS(KEY_SLOTS)
  ) u_ctrl (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .start_i           (start_i),
    .keyboard_present_i(keyboard_present_i),
    .busy_o            (busy_o),
    .cmd_o             (cmd)
  );

  // slot table, compares and the held-back output word
  hkrd_datapath #(
    .KEY_SLOTS(KEY_SLOTS)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .modifier_bits_i(modifier_bits_i),
    .key_count_i    (key_count_i),
    .key_a_i        (key_a_i),
    .key_b_i        (key_b_i),
    .key_c_i        (key_c_i),
    .key_d_i        (key_d_i),
    .key_e_i        (key_e_i),
    .key_f_i        (key_f_i),
    .result_valid_o (result_valid_o),
    .pressed_o      (pressed_o),
    .code_o         (code_o),
    .last_o         (last_o)
  );

endmodule
`default_nettype wire

FILE: dv/tb_hid_keyboard_report_differ.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_hid_keyboard_report_differ
// self-checking bench for the keyboard report differ: a short table of
// directed reports, then random report streams under several gap patterns,
// with every key word scored against typed words or an in-bench model of the slot table
// ----------------------------------------------------------------------------
module tb_hid_keyboard_report_differ;
  import hkrd_pkg::*;

  localparam int SLOTS         = KEY_SLOTS_DEF;
  localparam int BUSY_CYCLES   = 16 + SLOTS;
  localparam int QUIET_LIMIT   = 2000;
  localparam int RANDOM_ITEMS  = 129;
  localparam int PHASE_ITEMS   = 43;
  localparam int MAX_PRINTED   = 40;
  localparam int MODEL_SOURCED = -1;

  // usage codes of the modifier keys
  localparam logic [7:0] CODE_LCTRL  = 8'hE0;
  localparam logic [7:0] CODE_LSHIFT = 8'hE1;
  localparam logic [7:0] CODE_LALT   = 8'hE2;
  localparam logic [7:0] CODE_LGUI   = 8'hE3;
  localparam logic [7:0] CODE_RCTRL  = 8'hE4;
  localparam logic [7:0] CODE_RSHIFT = 8'hE5;
  localparam logic [7:0] CODE_RALT   = 8'hE6;
  localparam logic [7:0] CODE_RGUI   = 8'hE7;

  // modifier bit visited at each position of the event sweep
  localparam logic [2:0] SWEEP_BIT [MOD_BITS] = '{3'd1, 3'd5, 3'd2, 3'd6,
                                                  3'd0, 3'd4, 3'd3, 3'd7};

  typedef enum int {PH_STEADY, PH_SENDER_GAPS, PH_LIGHT_GAPS} gap_phase_e;

  typedef struct packed {
    logic                         present;
    logic [7:0]                   modifiers;
    logic [2:0]                   key_count;
    logic [REPORT_KEYS-1:0][7:0]  keys;     // keys[0] is key_a
  } report_t;

  typedef struct packed {
    logic       pressed;
    logic [7:0] code;
    logic       last;
  } key_word_t;

  typedef struct {
    report_t rep;
    int      typed_n;   // words typed in by hand, or MODEL_SOURCED
  } row_t;

  logic       clk_i = 1'b0;
  logic       rst_ni;
  logic       start_i;
  logic       busy_o;
  logic       keyboard_present_i;
  logic [7:0] modifier_bits_i;
  logic [2:0] key_count_i;
  logic [7:0] key_a_i, key_b_i, key_c_i, key_d_i, key_e_i, key_f_i;
  logic       result_valid_o;
  logic       pressed_o;
  logic [7:0] code_o;
  logic       last_o;

  // bench copy of the block state
  logic [7:0] slot_code [SLOTS];
  logic [7:0] held_modifiers;

  key_word_t  expected_words [$];
  key_word_t  model_words [$];
  key_word_t  typed_words [$];
  row_t       directed_rows [$];

  int mismatches   = 0;
  int words_seen   = 0;
  int reports_sent = 0;
  int absent_sent  = 0;
  int widest_burst = 0;
  int quiet_cycles = 0;

  hid_keyboard_report_differ #(
    .KEY_SLOTS(SLOTS)
  ) u_top (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .start_i           (start_i),
    .busy_o            (busy_o),
    .keyboard_present_i(keyboard_present_i),
    .modifier_bits_i   (modifier_bits_i),
    .key_count_i       (key_count_i),
    .key_a_i           (key_a_i),
    .key_b_i           (key_b_i),
    .key_c_i           (key_c_i),
    .key_d_i           (key_d_i),
    .key_e_i           (key_e_i),
    .key_f_i           (key_f_i),
    .result_valid_o    (result_valid_o),
    .pressed_o         (pressed_o),
    .code_o            (code_o),
    .last_o            (last_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= MAX_PRINTED) begin
      $display("mismatch @%0t: %s", $time, what);
    end
  endtask

  // works out the key words one report causes and updates the slot table;
  // the words land in model_words
  function automatic void diff_report(input report_t r);
    int         n_keys;
    int         i;
    int         j;
    logic [2:0] b;
    logic [7:0] k;
    logic [7:0] changed;
    logic       found;
    model_words.delete();
    // no keyboard: forget every held key, modifiers stay as they were
    if (!r.present) begin
      for (j = 0; j < SLOTS; j++) begin
        slot_code[j] = '0;
      end
      return;
    end
    // a count of seven reads as a full report
    n_keys = (r.key_count > REPORT_KEYS) ? REPORT_KEYS : int'(r.key_count);

    // modifier edges, in sweep order
    changed = r.modifiers ^ held_modifiers;
    for (i = 0; i < MOD_BITS; i++) begin
      b = SWEEP_BIT[i];
      if (changed[b]) begin
        model_words.push_back('{pressed: r.modifiers[b], code: {MOD_CODE_BASE, b},
                                last: 1'b0});
      end
    end
    held_modifiers = r.modifiers;

    // new keys take the first free slot; no free slot drops the key
    for (i = 0; i < n_keys; i++) begin
      k = r.keys[i];
      if (k == 8'h00) continue;
      found = 1'b0;
      for (j = 0; j < SLOTS; j++) begin
        if (slot_code[j] == k) found = 1'b1;
      end
      if (found) continue;
      for (j = 0; j < SLOTS; j++) begin
        if (slot_code[j] == 8'h00) begin
          slot_code[j] = k;
          model_words.push_back('{pressed: 1'b1, code: k, last: 1'b0});
          break;
        end
      end
    end

    // held keys missing from the report are released in slot order
    for (j = 0; j < SLOTS; j++) begin
      k = slot_code[j];
      if (k == 8'h00) continue;
      found = 1'b0;
      for (i = 0; i < n_keys; i++) begin
        if (r.keys[i] == k) found = 1'b1;
      end
      if (!found) begin
        model_words.push_back('{pressed: 1'b0, code: k, last: 1'b0});
        slot_code[j] = 8'h00;
      end
    end

    if (model_words.size() > 0) begin
      model_words[model_words.size() - 1].last = 1'b1;
    end
  endfunction

  // books the words of an accepted report, either hand-typed ones or the model's
  task automatic book_report(input report_t r, input int typed_n);
    diff_report(r);
    reports_sent++;
    if (!r.present) absent_sent++;
    if (typed_n == MODEL_SOURCED) begin
      foreach (model_words[n]) expected_words.push_back(model_words[n]);
      if (model_words.size() > widest_burst) widest_burst = model_words.size();
    end else begin
      repeat (typed_n) expected_words.push_back(typed_words.pop_front());
      if (typed_n > widest_burst) widest_burst = typed_n;
    end
  endtask

  // entered at a falling edge, returns at the falling edge after acceptance
  task automatic send_report(input report_t r, input int gap_pct);
    while ($urandom_range(99) < gap_pct) begin
      start_i <= 1'b0;
      @(negedge clk_i);
    end
    start_i            <= 1'b1;
    keyboard_present_i <= r.present;
    modifier_bits_i    <= r.modifiers;
    key_count_i        <= r.key_count;
    key_a_i            <= r.keys[0];
    key_b_i            <= r.keys[1];
    key_c_i            <= r.keys[2];
    key_d_i            <= r.keys[3];
    key_e_i            <= r.keys[4];
    key_f_i            <= r.keys[5];
    // start stays up while the block is busy
    do @(posedge clk_i); while (busy_o);
    @(negedge clk_i);
  endtask

  task automatic add_row(input logic present, input logic [7:0] mods,
                         input logic [2:0] n_keys, input logic [7:0] a,
                         input logic [7:0] b, input logic [7:0] c, input logic [7:0] d,
                         input logic [7:0] e, input logic [7:0] f, input int typed_n);
    row_t row;
    row.rep     = '{present: present, modifiers: mods, key_count: n_keys,
                    keys: {f, e, d, c, b, a}};
    row.typed_n = typed_n;
    directed_rows.push_back(row);
  endtask

  task automatic typed_word(input logic p, input logic [7:0] code, input logic last);
    typed_words.push_back('{pressed: p, code: code, last: last});
  endtask

  // all eight modifiers flipping in the same direction
  task automatic typed_modifier_sweep(input logic p);
    typed_word(p, CODE_LSHIFT, 1'b0);
    typed_word(p, CODE_RSHIFT, 1'b0);
    typed_word(p, CODE_LALT,   1'b0);
    typed_word(p, CODE_RALT,   1'b0);
    typed_word(p, CODE_LCTRL,  1'b0);
    typed_word(p, CODE_RCTRL,  1'b0);
    typed_word(p, CODE_LGUI,   1'b0);
    typed_word(p, CODE_RGUI,   1'b1);
  endtask

  // random report loosely following the previous one so keys stay held,
  // get released and refill slots; full-range codes and absent boards are noise
  function automatic report_t random_report(input report_t prev);
    report_t r;
    int      i;
    int      pick;
    r         = prev;
    r.present = ($urandom_range(99) >= 8);
    case ($urandom_range(3))
      0:       r.modifiers = 8'($urandom_range(255));
      1:       r.modifiers = prev.modifiers ^ (8'h01 << $urandom_range(7));
      default: r.modifiers = prev.modifiers;
    endcase
    r.key_count = 3'($urandom_range(7));
    for (i = 0; i < REPORT_KEYS; i++) begin
      pick = $urandom_range(9);
      if (pick < 4) begin
        r.keys[i] = prev.keys[i];
      end else if (pick < 7) begin
        r.keys[i] = 8'(8'h04 + $urandom_range(9));    // small pool forces repeats
      end else if (pick < 8) begin
        r.keys[i] = 8'h00;
      end else begin
        r.keys[i] = 8'($urandom_range(255));
      end
    end
    return r;
  endfunction

  function automatic int gap_percent(input gap_phase_e ph);
    case (ph)
      PH_SENDER_GAPS: return 59;
      PH_LIGHT_GAPS:  return 10;
      default:        return 0;
    endcase
  endfunction

  // score every word on the strobe against the oldest booked one
  always @(posedge clk_i) begin : score_words
    key_word_t want;
    if (rst_ni && result_valid_o) begin
      if (expected_words.size() == 0) begin
        report_mismatch($sformatf("unexpected word pressed=%0b code=%0h last=%0b",
                                  pressed_o, code_o, last_o));
      end else begin
        want = expected_words.pop_front();
        words_seen++;
        if (pressed_o !== want.pressed) begin
          report_mismatch($sformatf("code %0h: pressed %0b, want %0b",
                                    want.code, pressed_o, want.pressed));
        end
        if (code_o !== want.code) begin
          report_mismatch($sformatf("code %0h, want %0h", code_o, want.code));
        end
        if (last_o !== want.last) begin
          report_mismatch($sformatf("code %0h: last %0b, want %0b",
                                    want.code, last_o, want.last));
        end
      end
    end
  end

  // watchdog: cycles with neither a report taken nor a word out
  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || result_valid_o) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("timeout: nothing moved for %0d cycles, %0d words outstanding",
               QUIET_LIMIT, expected_words.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin : stimulus
    report_t    r;
    gap_phase_e ph;
    int         n;

    rst_ni             = 1'b0;
    start_i            = 1'b0;
    keyboard_present_i = 1'b0;
    modifier_bits_i    = '0;
    key_count_i        = '0;
    key_a_i            = '0;
    key_b_i            = '0;
    key_c_i            = '0;
    key_d_i            = '0;
    key_e_i            = '0;
    key_f_i            = '0;
    for (n = 0; n < SLOTS; n++) slot_code[n] = '0;
    held_modifiers = '0;

    // directed table: present, modifiers, count, key_a .. key_f, typed words
    // nothing changed right after reset
    add_row(1'b1, 8'h00, 3'd0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 0);
    // no keyboard: silent whatever the fields hold
    add_row(1'b0, 8'hFF, 3'd6, 8'h04, 8'h05, 8'h06, 8'h07, 8'h08, 8'h09, 0);
    // every modifier goes down, then every one comes up
    add_row(1'b1, 8'hFF, 3'd0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8);
    typed_modifier_sweep(1'b1);
    add_row(1'b1, 8'h00, 3'd0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8);
    typed_modifier_sweep(1'b0);
    // six fresh keys fill every slot
    add_row(1'b1, 8'h00, 3'd6, 8'h04, 8'h05, 8'h06, 8'h07, 8'h08, 8'h09, 6);
    for (n = 4; n <= 9; n++) typed_word(1'b1, 8'(n), n == 9);
    // table full: six new keys are dropped, the old six are released
    add_row(1'b1, 8'h00, 3'd6, 8'h0A, 8'h0B, 8'h0C, 8'h0D, 8'h0E, 8'h0F, MODEL_SOURCED);
    add_row(1'b1, 8'h00, 3'd0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, MODEL_SOURCED);
    // code extremes with an empty code in the middle
    add_row(1'b1, 8'h00, 3'd6, 8'hFF, 8'h01, 8'h80, 8'h7F, 8'h00, 8'hFE, MODEL_SOURCED);
    // count of seven reads as six
    add_row(1'b1, 8'h00, 3'd7, 8'hFF, 8'h01, 8'h80, 8'h7F, 8'h00, 8'hFE, MODEL_SOURCED);
    // keys past the count are released
    add_row(1'b1, 8'h00, 3'd2, 8'hFF, 8'h01, 8'h80, 8'h7F, 8'h00, 8'hFE, MODEL_SOURCED);
    // repeated codes in one report
    add_row(1'b1, 8'h00, 3'd6, 8'h11, 8'h11, 8'h11, 8'h22, 8'h22, 8'h00, MODEL_SOURCED);
    add_row(1'b1, 8'h00, 3'd3, 8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, MODEL_SOURCED);
    // unplug drops the table, replug presses the keys again
    add_row(1'b0, 8'h00, 3'd3, 8'h30, 8'h31, 8'h32, 8'h00, 8'h00, 8'h00, 0);
    add_row(1'b1, 8'h55, 3'd3, 8'h30, 8'h31, 8'h32, 8'h00, 8'h00, 8'h00, MODEL_SOURCED);
    add_row(1'b1, 8'hAA, 3'd3, 8'h30, 8'h31, 8'h32, 8'h00, 8'h00, 8'h00, MODEL_SOURCED);
    // absent report keeps the stored modifiers
    add_row(1'b0, 8'h00, 3'd0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 0);
    add_row(1'b1, 8'hAA, 3'd2, 8'h30, 8'h31, 8'h00, 8'h00, 8'h00, 8'h00, MODEL_SOURCED);
    // longest burst: all modifiers flip and six new keys land
    add_row(1'b0, 8'hAA, 3'd0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 0);
    add_row(1'b1, 8'h55, 3'd6, 8'h40, 8'h41, 8'h42, 8'h43, 8'h44, 8'h45, MODEL_SOURCED);
    add_row(1'b1, 8'h55, 3'd6, 8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h46, MODEL_SOURCED);
    add_row(1'b1, 8'h00, 3'd0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, MODEL_SOURCED);

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (directed_rows[i]) begin
      send_report(directed_rows[i].rep, gap_percent(PH_STEADY));
      book_report(directed_rows[i].rep, directed_rows[i].typed_n);
    end

    r = directed_rows[directed_rows.size() - 1].rep;
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      ph = gap_phase_e'(n / PHASE_ITEMS);
      r  = random_report(r);
      send_report(r, gap_percent(ph));
      book_report(r, MODEL_SOURCED);
    end
    start_i <= 1'b0;

    while (expected_words.size() != 0) @(posedge clk_i);
    // let any late stray word show up
    repeat (2 * BUSY_CYCLES) @(posedge clk_i);

    $display("run covered %0d reports (%0d with no keyboard), %0d key words scored",
             reports_sent, absent_sent, words_seen);
    $display("longest burst from one report: %0d words", widest_burst);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
